@@ rtl/prd_pkg.sv @@
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types, constants and helpers for the pinhole ray direction unit.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int unsigned DimBitsDef = 12;
  localparam int unsigned DimW       = 13;
  localparam int unsigned TanW       = 20;
  localparam int unsigned ProdW      = DimW + TanW;  // |A|, |B| width
  localparam int unsigned NormW      = 31;           // normalized magnitude width
  localparam int unsigned SumW       = 64;
  localparam int unsigned RootW      = 32;
  localparam int unsigned QuotW      = 17;
  localparam int unsigned LenW       = 6;
  localparam int unsigned UnitOne    = 65536;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegTan    = 3'd2,
    RegCamX   = 3'd3,
    RegCamY   = 3'd4,
    RegCamZ   = 3'd5
  } prd_reg_e;

  // normalized vector with signs
  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic [NormW-1:0] mag_a;
    logic [NormW-1:0] mag_b;
    logic [NormW-1:0] mag_c;
  } prd_vec_t;

  function automatic logic [LenW-1:0] bit_len(input logic [ProdW-1:0] v);
    logic [LenW-1:0] n;
    n = '0;
    for (int i = 0; i < ProdW; i++) begin
      if (v[i]) n = LenW'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ rtl/prd_front.sv @@
// ----------------------------------------------------------------------------
// prd_front
// Forms (A, B, C), normalizes it to 31 bits and sums the squares.
// Six register stages.
// ----------------------------------------------------------------------------
module prd_front import prd_pkg::*; #(
  parameter int unsigned DIM_BITS = DimBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [11:0]      pixel_x_i,
  input  logic [11:0]      pixel_y_i,
  input  logic [DimW-1:0]  width_i,
  input  logic [DimW-1:0]  height_i,
  input  logic [TanW-1:0]  tan_i,
  output logic             valid_o,
  output logic [SumW-1:0]  sum_o,
  output prd_vec_t         vec_o
);

  localparam logic [16:0] DimLim = 17'(1 << DIM_BITS);

  logic [5:0] vld_q;

  // stage 1: clamp dims, centered offsets
  logic [DimW-1:0] w_c, h_c, tx, ty;
  logic            s1_nx_d, s1_ny_d;
  logic [DimW-1:0] s1_dx_d, s1_dy_d;
  logic            s1_nx_q, s1_ny_q;
  logic [DimW-1:0] s1_dx_q, s1_dy_q, s1_h_q;

  always_comb begin
    w_c = (width_i == '0) ? DimW'(1) :
          ({4'b0, width_i} > DimLim) ? DimW'(DimLim) : width_i;
    h_c = (height_i == '0) ? DimW'(1) :
          ({4'b0, height_i} > DimLim) ? DimW'(DimLim) : height_i;
    tx = {pixel_x_i, 1'b1};
    ty = {pixel_y_i, 1'b1};
    s1_nx_d = tx < w_c;
    s1_ny_d = h_c < ty;
    s1_dx_d = s1_nx_d ? (w_c - tx) : (tx - w_c);
    s1_dy_d = s1_ny_d ? (ty - h_c) : (h_c - ty);
  end

  // stage 2: products
  logic             s2_nx_q, s2_ny_q;
  logic [ProdW-1:0] s2_a_q, s2_b_q, s2_c_q;
  // stage 3: bit length of max
  logic             s3_nx_q, s3_ny_q;
  logic [ProdW-1:0] s3_a_q, s3_b_q, s3_c_q;
  logic [LenW-1:0]  s3_len_q;
  logic [ProdW-1:0] m_ab, m_abc;
  // stage 4: normalize
  prd_vec_t         s4_vec_d, s4_vec_q;
  // stage 5: squares
  prd_vec_t         s5_vec_q;
  logic [2*NormW-1:0] sq_a_q, sq_b_q, sq_c_q;
  // stage 6: sum
  prd_vec_t         s6_vec_q;
  logic [SumW-1:0]  s6_sum_q;

  always_comb begin
    m_ab  = (s2_a_q > s2_b_q) ? s2_a_q : s2_b_q;
    m_abc = (m_ab > s2_c_q) ? m_ab : s2_c_q;
  end

  always_comb begin
    logic [LenW-1:0] rs, ls;
    rs = s3_len_q - LenW'(NormW);
    ls = LenW'(NormW) - s3_len_q;
    s4_vec_d.neg_x = s3_nx_q;
    s4_vec_d.neg_y = s3_ny_q;
    if (s3_len_q > LenW'(NormW)) begin
      s4_vec_d.mag_a = NormW'(s3_a_q >> rs);
      s4_vec_d.mag_b = NormW'(s3_b_q >> rs);
      s4_vec_d.mag_c = NormW'(s3_c_q >> rs);
    end else begin
      s4_vec_d.mag_a = NormW'(s3_a_q << ls);
      s4_vec_d.mag_b = NormW'(s3_b_q << ls);
      s4_vec_d.mag_c = NormW'(s3_c_q << ls);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_nx_q  <= s1_nx_d;
      s1_ny_q  <= s1_ny_d;
      s1_dx_q  <= s1_dx_d;
      s1_dy_q  <= s1_dy_d;
      s1_h_q   <= h_c;
      s2_nx_q  <= s1_nx_q;
      s2_ny_q  <= s1_ny_q;
      s2_a_q   <= ProdW'(s1_dx_q * tan_i);
      s2_b_q   <= ProdW'(s1_dy_q * tan_i);
      s2_c_q   <= ProdW'({s1_h_q, 16'b0});
      s3_nx_q  <= s2_nx_q;
      s3_ny_q  <= s2_ny_q;
      s3_a_q   <= s2_a_q;
      s3_b_q   <= s2_b_q;
      s3_c_q   <= s2_c_q;
      s3_len_q <= bit_len(m_abc);
      s4_vec_q <= s4_vec_d;
      s5_vec_q <= s4_vec_q;
      sq_a_q   <= s4_vec_q.mag_a * s4_vec_q.mag_a;
      sq_b_q   <= s4_vec_q.mag_b * s4_vec_q.mag_b;
      sq_c_q   <= s4_vec_q.mag_c * s4_vec_q.mag_c;
      s6_vec_q <= s5_vec_q;
      s6_sum_q <= SumW'(sq_a_q) + SumW'(sq_b_q) + SumW'(sq_c_q);
    end
  end

  assign valid_o = vld_q[5];
  assign sum_o   = s6_sum_q;
  assign vec_o   = s6_vec_q;

endmodule

@@ rtl/prd_sqrt.sv @@
// ----------------------------------------------------------------------------
// prd_sqrt
// Integer square root, one result bit per register stage (32 stages).
// ----------------------------------------------------------------------------
module prd_sqrt import prd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SumW-1:0]  sum_i,
  input  prd_vec_t         vec_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output prd_vec_t         vec_o
);

  localparam int unsigned RemW = RootW + 2;

  logic [RootW-1:0] vld_q;
  logic [SumW-1:0]  s_q    [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  prd_vec_t         vec_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [SumW-1:0]  s_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    prd_vec_t         vec_in;
    logic [RemW+1:0]  r2, trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign s_in    = sum_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vec_in  = vec_i;
    end else begin : g_next
      assign s_in    = s_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vec_in  = vec_q[k-1];
    end

    always_comb begin
      r2    = {rem_in, s_in[SumW-1 -: 2]};
      trial = {2'b0, root_in, 2'b01};
      ge    = r2 >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]    <= {s_in[SumW-3:0], 2'b00};
        rem_q[k]  <= ge ? RemW'(r2 - trial) : RemW'(r2);
        root_q[k] <= {root_in[RootW-2:0], ge};
        vec_q[k]  <= vec_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign vec_o   = vec_q[RootW-1];

endmodule

@@ rtl/prd_div.sv @@
// ----------------------------------------------------------------------------
// prd_div
// Three rounded divisions mag*2^16/root, one quotient bit per stage.
// ----------------------------------------------------------------------------
module prd_div import prd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RootW-1:0] root_i,
  input  prd_vec_t         vec_i,
  output logic             valid_o,
  output logic             neg_x_o,
  output logic             neg_y_o,
  output logic [QuotW-1:0] quot_o [3]
);

  localparam int unsigned NumW = NormW + 16 + 2;

  logic [QuotW-1:0] vld_q;
  logic [NumW-1:0]  rem_q  [QuotW][3];
  logic [QuotW-1:0] quot_q [QuotW][3];
  logic [RootW-1:0] den_q  [QuotW];
  logic [1:0]       neg_q  [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [RootW-1:0] den_in;
    logic [1:0]       neg_in;
    logic [NumW-1:0]  dsh;

    assign dsh = NumW'(den_in) << (QuotW - 1 - k);

    if (k == 0) begin : g_first
      assign den_in = root_i;
      assign neg_in = {vec_i.neg_y, vec_i.neg_x};
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NumW-1:0]  rem_in;
      logic [QuotW-1:0] q_in;
      logic             ge;

      if (k == 0) begin : g_first
        logic [NormW-1:0] mag;
        assign mag    = (l == 0) ? vec_i.mag_a : (l == 1) ? vec_i.mag_b : vec_i.mag_c;
        // rounding: add half the divisor
        assign rem_in = {2'b0, mag, 16'b0} + NumW'(root_i >> 1);
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign q_in   = quot_q[k-1][l];
      end

      assign ge = rem_in >= dsh;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l]  <= ge ? (rem_in - dsh) : rem_in;
          quot_q[k][l] <= {q_in[QuotW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotW-2:0], valid_i};
    end
  end

  assign valid_o   = vld_q[QuotW-1];
  assign neg_x_o   = neg_q[QuotW-1][0];
  assign neg_y_o   = neg_q[QuotW-1][1];
  assign quot_o[0] = quot_q[QuotW-1][0];
  assign quot_o[1] = quot_q[QuotW-1][1];
  assign quot_o[2] = quot_q[QuotW-1][2];

endmodule

@@ rtl/pinhole_ray_direction_unit.sv @@
// ----------------------------------------------------------------------------
// pinhole_ray_direction_unit
// Pinhole camera primary ray: pixel in, unit direction and origin out.
//
//   channel  | handshake                 | words
//   ---------+---------------------------+---------------------------------
//   pixel    | in_valid_i / in_ready_o   | pixel_x_i, pixel_y_i
//   ray      | out_valid_o / out_ready_i | dir_x/y/z_o, origin_x/y/z_o
//   config   | APB psel/penable/pready   | six registers at 4*i
//
// One word per cycle while the output is not stalled; 6 setup stages,
// 32 square-root bit stages, 17 divider bit stages, 1 output register.
// The whole pipe advances together; it holds while the output word waits.
// Reset clears valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_unit import prd_pkg::*; #(
  parameter int unsigned DIM_BITS = DimBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        pixel_x_i,
  input  logic [11:0]        pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] dir_x_o,
  output logic signed [17:0] dir_y_o,
  output logic [16:0]        dir_z_o,
  output logic signed [31:0] origin_x_o,
  output logic signed [31:0] origin_y_o,
  output logic signed [31:0] origin_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [DimW-1:0] width_q, height_q;
  logic [TanW-1:0] tan_q;
  logic [31:0]     cam_x_q, cam_y_q, cam_z_q;
  prd_reg_e        reg_sel;

  assign reg_sel = prd_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
      tan_q    <= TanW'(30560);
      cam_x_q  <= 32'sd0;
      cam_y_q  <= 32'sd262144;
      cam_z_q  <= -32'sd655360;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegWidth:  width_q  <= pwdata[DimW-1:0];
        RegHeight: height_q <= pwdata[DimW-1:0];
        RegTan:    tan_q    <= pwdata[TanW-1:0];
        RegCamX:   cam_x_q  <= pwdata;
        RegCamY:   cam_y_q  <= pwdata;
        RegCamZ:   cam_z_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      RegTan:    prdata = 32'(tan_q);
      RegCamX:   prdata = cam_x_q;
      RegCamY:   prdata = cam_y_q;
      RegCamZ:   prdata = cam_z_q;
      default:   prdata = '0;
    endcase
  end

  // pipe
  logic             en;
  logic             fr_valid, sq_valid, dv_valid;
  logic [SumW-1:0]  fr_sum;
  prd_vec_t         fr_vec, sq_vec;
  logic [RootW-1:0] sq_root;
  logic             dv_neg_x, dv_neg_y;
  logic [QuotW-1:0] dv_quot [3];
  logic             out_valid_q;
  logic [17:0]      dir_x_q, dir_y_q;
  logic [16:0]      dir_z_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  prd_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .pixel_x_i, .pixel_y_i,
    .width_i(width_q), .height_i(height_q), .tan_i(tan_q),
    .valid_o(fr_valid), .sum_o(fr_sum), .vec_o(fr_vec)
  );

  prd_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid),
    .sum_i(fr_sum), .vec_i(fr_vec),
    .valid_o(sq_valid), .root_o(sq_root), .vec_o(sq_vec)
  );

  prd_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_valid),
    .root_i(sq_root), .vec_i(sq_vec),
    .valid_o(dv_valid), .neg_x_o(dv_neg_x), .neg_y_o(dv_neg_y), .quot_o(dv_quot)
  );

  logic [16:0] cap_x, cap_y, cap_z;
  always_comb begin
    cap_x = (dv_quot[0] > 17'(UnitOne)) ? 17'(UnitOne) : dv_quot[0];
    cap_y = (dv_quot[1] > 17'(UnitOne)) ? 17'(UnitOne) : dv_quot[1];
    cap_z = (dv_quot[2] > 17'(UnitOne)) ? 17'(UnitOne) : dv_quot[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_x_q <= dv_neg_x ? (18'd0 - {1'b0, cap_x}) : {1'b0, cap_x};
      dir_y_q <= dv_neg_y ? (18'd0 - {1'b0, cap_y}) : {1'b0, cap_y};
      dir_z_q <= cap_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dir_x_o     = dir_x_q;
  assign dir_y_o     = dir_y_q;
  assign dir_z_o     = dir_z_q;
  // config is to be kept static by the user while words are in flight; not enforced here
  assign origin_x_o  = cam_x_q;
  assign origin_y_o  = cam_y_q;
  assign origin_z_o  = cam_z_q;

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dir_z_o <= 17'(UnitOne)))
    else $error("dir_z out of range");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dir_x_o <= 18'sd65536 && dir_x_o >= -18'sd65536))
    else $error("dir_x out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output word dropped");

endmodule

@@ bench/ray_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_checker
// Watches the pixel, ray and config channels of the ray direction unit,
// predicts each ray word from its own register copy and compares them.
// ----------------------------------------------------------------------------
module ray_checker import prd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [11:0]        pixel_x_i,
  input  logic [11:0]        pixel_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic [16:0]        dir_z_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [17:0] dx;
    logic [17:0] dy;
    logic [16:0] dz;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
  } ray_t;

  logic [12:0] width_q, height_q;
  logic [19:0] tan_q;
  logic [31:0] cam_x_q, cam_y_q, cam_z_q;
  ray_t        ray_queue[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = ray_queue.size();

  function automatic logic [63:0] clamp_dim(logic [12:0] d);
    logic [63:0] lim;
    lim = 64'd1 << DimBitsDef;
    if (d == 0) return 64'd1;
    if (64'(d) > lim) return lim;
    return 64'(d);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] unit_mag(logic [63:0] mag, logic [63:0] r, logic neg);
    logic [63:0] q;
    q = ((mag << 16) + (r >> 1)) / r;
    if (q > 64'd65536) q = 64'd65536;
    if (neg) q = 64'd0 - q;
    return q;
  endfunction

  function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
    logic [63:0] w, h, tx, ty, nx, ny, a, b, c, m, r;
    logic        negx, negy;
    int          len;
    ray_t        ray;
    w = clamp_dim(width_q);
    h = clamp_dim(height_q);
    tx = 2 * 64'(px) + 1;
    ty = 2 * 64'(py) + 1;
    negx = tx < w;
    negy = h < ty;
    nx = negx ? w - tx : tx - w;
    ny = negy ? ty - h : h - ty;
    a = nx * 64'(tan_q);
    b = ny * 64'(tan_q);
    c = h << 16;
    m = c;
    if (a > m) m = a;
    if (b > m) m = b;
    len = 0;
    for (int i = 0; i < 64; i++) if (m[i]) len = i + 1;
    // bring the largest magnitude into [2^30, 2^31)
    if (len > 31) begin
      a >>= (len - 31); b >>= (len - 31); c >>= (len - 31);
    end else begin
      a <<= (31 - len); b <<= (31 - len); c <<= (31 - len);
    end
    r = floor_sqrt(a * a + b * b + c * c);
    ray.dx = 18'(unit_mag(a, r, negx && a != 0));
    ray.dy = 18'(unit_mag(b, r, negy && b != 0));
    ray.dz = 17'(unit_mag(c, r, 1'b0));
    ray.ox = cam_x_q;
    ray.oy = cam_y_q;
    ray.oz = cam_z_q;
    return ray;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ray_t got, want;
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      tan_q    <= 20'd30560;
      cam_x_q  <= 32'd0;
      cam_y_q  <= 32'd262144;
      cam_z_q  <= -32'sd655360;
      fails    = 0;
      ray_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (prd_reg_e'(paddr[4:2]))
          RegWidth:  width_q  <= pwdata[12:0];
          RegHeight: height_q <= pwdata[12:0];
          RegTan:    tan_q    <= pwdata[19:0];
          RegCamX:   cam_x_q  <= pwdata;
          RegCamY:   cam_y_q  <= pwdata;
          RegCamZ:   cam_z_q  <= pwdata;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        ray_queue.insert(ray_queue.size(), predict_ray(pixel_x_i, pixel_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{dir_x_i, dir_y_i, dir_z_i, origin_x_i, origin_y_i, origin_z_i};
        if (ray_queue.size() == 0) begin
          $error("ray word with no pending pixel");
          fails++;
        end else begin
          want = ray_queue.pop_front();
          if (got.dx !== want.dx) begin
            $error("dir_x expected %0d got %0d", $signed(want.dx), $signed(got.dx));
            fails++;
          end
          if (got.dy !== want.dy) begin
            $error("dir_y expected %0d got %0d", $signed(want.dy), $signed(got.dy));
            fails++;
          end
          if (got.dz !== want.dz) begin
            $error("dir_z expected %0d got %0d", want.dz, got.dz);
            fails++;
          end
          if (got.ox !== want.ox) begin
            $error("origin_x expected %0d got %0d", $signed(want.ox), $signed(got.ox));
            fails++;
          end
          if (got.oy !== want.oy) begin
            $error("origin_y expected %0d got %0d", $signed(want.oy), $signed(got.oy));
            fails++;
          end
          if (got.oz !== want.oz) begin
            $error("origin_z expected %0d got %0d", $signed(want.oz), $signed(got.oz));
            fails++;
          end
        end
      end
    end
  end

endmodule

@@ bench/tb_pinhole_ray_direction_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pinhole_ray_direction_unit
// Drives pixels and camera settings into the ray direction unit with random
// gaps and output stalls; the checker predicts and compares every ray word.
// ----------------------------------------------------------------------------
module tb_pinhole_ray_direction_unit import prd_pkg::*; ();

  localparam int CycleLimit = 400000;
  localparam int Latency    = 56;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [11:0] pixel_x_i = '0, pixel_y_i = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_ready_o, out_valid_o, pready;
  logic signed [17:0] dir_x_o, dir_y_o;
  logic [16:0] dir_z_o;
  logic signed [31:0] origin_x_o, origin_y_o, origin_z_o;
  logic [31:0] prdata;
  int fail_count, pending, cycles;
  logic no_idle = 1'b0;
  int cur_w = 640, cur_h = 480;

  always #5 clk_i = ~clk_i;

  pinhole_ray_direction_unit dut (.*);

  ray_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .pixel_x_i, .pixel_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .dir_x_i(dir_x_o), .dir_y_i(dir_y_o),
    .dir_z_i(dir_z_o), .origin_x_i(origin_x_o), .origin_y_i(origin_y_o),
    .origin_z_i(origin_z_o), .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_pinhole_ray_direction_unit failed");
      $finish;
    end
  end

  // receiver: random stall before each word, none while no_idle is set
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(prd_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == RegWidth) cur_w = int'(val[12:0]);
    if (idx == RegHeight) cur_h = int'(val[12:0]);
  endtask

  task automatic set_camera(int w, int h, logic [19:0] t, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] cz);
    // config only while idle
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegTan, 32'(t));
    write_reg(RegCamX, cx);
    write_reg(RegCamY, cy);
    write_reg(RegCamZ, cz);
  endtask

  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_x_i  = px;
    pixel_y_i  = py;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic random_pixels(int count);
    int lim_x, lim_y;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      lim_x = (cur_w < 1) ? 0 : ((cur_w > 4096) ? 4095 : cur_w - 1);
      lim_y = (cur_h < 1) ? 0 : ((cur_h > 4096) ? 4095 : cur_h - 1);
      if ($urandom_range(0, 4) != 0) begin
        send_pixel(12'($urandom_range(0, lim_x)), 12'($urandom_range(0, lim_y)));
      end else begin
        send_pixel(12'($urandom), 12'($urandom));
      end
    end
    in_valid_i = 1'b0;
    no_idle = 1'b0;
  endtask

  initial begin
    int w, h;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: corners, center, far pixels
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd319, 12'd239);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    in_valid_i = 1'b0;
    // zero dimensions, widest view: everything off the image
    set_camera(0, 0, 20'hFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd2048);
    // oversized dimensions, zero view
    set_camera(8191, 8191, 20'd0, 32'h80000000, 32'h7FFFFFFF, 32'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2047, 12'd2048);
    // largest legal sizes, wide view
    set_camera(4096, 4096, 20'hFFFFF, 32'd1, 32'd0, 32'h80000000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2047);
    // one-pixel frame
    set_camera(1, 1, 20'd65536, 32'd0, 32'd0, 32'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    in_valid_i = 1'b0;

    random_pixels(250);
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
        1: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
        2: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
        default: begin w = 4096; h = 1; end
      endcase
      set_camera(w, h, 20'($urandom), $urandom, $urandom, $urandom);
      random_pixels(230);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_pinhole_ray_direction_unit passed");
    end else begin
      $display("tb_pinhole_ray_direction_unit failed");
    end
    $finish;
  end

endmodule
